@@ sv/rkd_pkg.sv @@
`default_nettype none

package rkd_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 8;

  // Items that can still reach the queue after the one now accepted:
  // the two front stages plus the new transfer itself.
  localparam int IN_FLIGHT = 3;

  localparam int DIVISOR = 100;

  // ceil(2^38 / 100): exact floor(m / 100) for every 31-bit m.
  localparam int          RECIP_SHIFT = 38;
  localparam logic [31:0] RECIP       = 32'd2748779070;

  // Fraction bits appended below the integer quotient.
  localparam int FRAC_BITS = 33;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
  localparam logic [11:0] INT_BASE_EXP = 12'd1043;
  localparam logic [10:0] INT_CONV_EXP = 11'd1053;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

  // Entry handed from the front to the back.
  typedef struct packed {
    logic               calc;    // value must go through the divider
    logic               sign;
    logic [30:0]        mant;    // normalized, bit 30 set
    logic signed [12:0] xe;      // base exponent minus leading zero count
    logic [63:0]        bypass;  // finished pattern when calc is low
  } rkd_item_t;

  typedef logic [FRAC_BITS-1:0] frac_tbl_t [DIVISOR];

  // floor(r * 2^33 / 100) for each remainder r, built at elaboration.
  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int r = 0; r < DIVISOR; r++) begin
      t[r] = FRAC_BITS'((longint'(r) << FRAC_BITS) / DIVISOR);
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

endpackage

`default_nettype wire

@@ sv/rkd_front.sv @@
`default_nettype none

module rkd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [31:0]        rk_word,
  output logic                    out_valid,
  output rkd_pkg::rkd_item_t      out_item
);
  import rkd_pkg::*;

  // Stage 1 registers.
  logic        v1;
  logic        calc1;
  logic        conv1;
  logic        sign1;
  logic [30:0] raw1;
  logic [11:0] base1;
  logic [63:0] bypass1;

  // Stage 2 registers.
  logic        v2;
  logic        calc2;
  logic        conv2;
  logic        sign2;
  logic [30:0] raw2;
  logic [1:0]  lz2;
  logic [11:0] base2;
  logic [63:0] bypass2;

  logic        calc_c;
  logic        conv_c;
  logic        sign_c;
  logic [30:0] raw_c;
  logic [11:0] base_c;
  logic [63:0] bypass_c;
  logic [29:0] u_c;
  logic [29:0] mag_c;
  logic [10:0] ex_c;
  logic [19:0] frac_c;
  logic [63:0] fbits_c;

  // Classify the word and pick the raw mantissa and base exponent.
  always_comb begin
    u_c      = rk_word[31:2];
    mag_c    = u_c[29] ? 30'(-u_c) : u_c;
    ex_c     = rk_word[30:20];
    frac_c   = {rk_word[19:2], 2'b00};
    fbits_c  = {rk_word[31:2], 2'b00, 32'd0};
    calc_c   = 1'b0;
    conv_c   = 1'b0;
    sign_c   = 1'b0;
    raw_c    = 31'd0;
    base_c   = 12'd0;
    bypass_c = 64'd0;
    if (rk_word[1]) begin
      sign_c = u_c[29];
      raw_c  = {1'b0, mag_c};
      base_c = INT_BASE_EXP;
      if (u_c != 30'd0) begin
        calc_c = rk_word[0];
        conv_c = !rk_word[0];
      end
    end else begin
      sign_c   = rk_word[31];
      bypass_c = fbits_c;
      if (ex_c == 11'd0) begin
        raw_c  = {11'd0, frac_c};
        base_c = 12'd1;
      end else begin
        raw_c  = {10'd0, 1'b1, frac_c};
        base_c = {1'b0, ex_c};
      end
      if (rk_word[0]) begin
        if (ex_c == EXP_ALL_ONES) begin
          if (frac_c != 20'd0) begin
            bypass_c = fbits_c | QUIET_BIT;
          end
        end else if (ex_c != 11'd0 || frac_c != 20'd0) begin
          calc_c = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // First half of the normalizing shift: steps of 16 and 8.
  logic [30:0] s16_c;
  logic [30:0] s8_c;
  logic        z16_c;
  logic        z8_c;

  always_comb begin
    z16_c = (raw1[30:15] == 16'd0);
    s16_c = z16_c ? {raw1[14:0], 16'd0} : raw1;
    z8_c  = (s16_c[30:23] == 8'd0);
    s8_c  = z8_c ? {s16_c[22:0], 8'd0} : s16_c;
  end

  always_ff @(posedge clk) begin
    calc1   <= calc_c;
    conv1   <= conv_c;
    sign1   <= sign_c;
    raw1    <= raw_c;
    base1   <= base_c;
    bypass1 <= bypass_c;
    calc2   <= calc1;
    conv2   <= conv1;
    sign2   <= sign1;
    raw2    <= s8_c;
    lz2     <= {z16_c, z8_c};
    base2   <= base1;
    bypass2 <= bypass1;
  end

  // Second half: steps of 4, 2 and 1, then the finished integer pattern.
  logic [30:0] s4_c;
  logic [30:0] s2_c;
  logic [30:0] s1_c;
  logic [4:0]  lz_c;
  logic [10:0] cexp_c;

  always_comb begin
    lz_c[4:3] = lz2;
    lz_c[2]   = (raw2[30:27] == 4'd0);
    s4_c      = lz_c[2] ? {raw2[26:0], 4'd0} : raw2;
    lz_c[1]   = (s4_c[30:29] == 2'd0);
    s2_c      = lz_c[1] ? {s4_c[28:0], 2'd0} : s4_c;
    lz_c[0]   = !s2_c[30];
    s1_c      = lz_c[0] ? {s2_c[29:0], 1'b0} : s2_c;
    cexp_c    = INT_CONV_EXP - 11'(lz_c);

    out_valid       = v2;
    out_item.calc   = calc2;
    out_item.sign   = sign2;
    out_item.mant   = s1_c;
    out_item.xe     = $signed({1'b0, base2}) - $signed({8'd0, lz_c});
    out_item.bypass = conv2 ? {sign2, cexp_c, s1_c[29:0], 22'd0} : bypass2;
  end

endmodule

`default_nettype wire

@@ sv/rkd_queue.sv @@
`default_nettype none

module rkd_queue #(
  parameter int DEPTH = rkd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire rkd_pkg::rkd_item_t           push_item,
  output logic                              head_valid,
  output rkd_pkg::rkd_item_t                head_item,
  output logic [$clog2(DEPTH+1)-1:0]        level
);
  import rkd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rkd_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  // The back takes the head in every cycle that it holds one.
  assign pop        = (count != CNT_W'(0));
  assign head_valid = pop;
  assign head_item  = slots[rd_ptr];
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ sv/rkd_back.sv @@
`default_nettype none

module rkd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire rkd_pkg::rkd_item_t in_item,
  output logic                    done,
  output logic [63:0]             double_bits
);
  import rkd_pkg::*;

  localparam int QW = 25 + FRAC_BITS;

  logic [3:0]  v;

  // Stage 1: integer quotient by the reciprocal.
  logic        calc1;
  logic        sign1;
  logic [30:0] mant1;
  logic signed [12:0] xe1;
  logic [63:0] byp1;
  logic [24:0] quo1;
  logic [62:0] prod_c;

  // Stage 2: remainder.
  logic        calc2;
  logic        sign2;
  logic signed [12:0] xe2;
  logic [63:0] byp2;
  logic [24:0] quo2;
  logic [6:0]  rem2;
  logic [31:0] back_c;

  // Stage 3: full quotient, exponent and shift amount.
  logic          calc3;
  logic          sign3;
  logic [63:0]   byp3;
  logic [QW-1:0] q3;
  logic          rs3;
  logic signed [13:0] be3;
  logic [5:0]    sh3;
  logic [QW-1:0] q_c;
  logic signed [13:0] be_c;
  logic [5:0]    sh_c;

  // Stage 4: aligned mantissa with guard and sticky.
  logic          calc4;
  logic          sign4;
  logic [63:0]   byp4;
  logic [52:0]   mant4;
  logic          g4;
  logic          s4;
  logic [10:0]   eff4;
  logic [QW-1:0] shifted_c;
  logic [QW-1:0] lowmask_c;

  always_comb begin
    prod_c = 63'(in_item.mant) * 63'(RECIP);
    back_c = 32'(quo1) * 32'(DIVISOR);
  end

  always_comb begin
    q_c  = {quo2, FRAC_TBL[rem2]};
    be_c = 14'(xe2) + 14'sd3 + $signed({13'd0, q_c[QW-1]});
    sh_c = q_c[QW-1] ? 6'd5 : 6'd4;
    if (be_c < 14'sd1) begin
      sh_c = sh_c + 6'(14'sd1 - be_c);
    end
  end

  always_comb begin
    shifted_c = q3 >> sh3;
    lowmask_c = (QW'(1) << (sh3 - 6'd1)) - QW'(1);
  end

  // Rounding to nearest-even and packing.
  logic        inc_c;
  logic [62:0] mag_c;

  always_comb begin
    inc_c = g4 & (s4 | mant4[0]);
    mag_c = {eff4, 52'd0} + 63'(mant4) + 63'(inc_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[2:0], in_valid};
      done <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    calc1 <= in_item.calc;
    sign1 <= in_item.sign;
    mant1 <= in_item.mant;
    xe1   <= in_item.xe;
    byp1  <= in_item.bypass;
    quo1  <= prod_c[62:RECIP_SHIFT];

    calc2 <= calc1;
    sign2 <= sign1;
    xe2   <= xe1;
    byp2  <= byp1;
    quo2  <= quo1;
    rem2  <= 7'({1'b0, mant1} - back_c);

    calc3 <= calc2;
    sign3 <= sign2;
    byp3  <= byp2;
    q3    <= q_c;
    rs3   <= !(rem2 == 7'd0 || rem2 == 7'd25 || rem2 == 7'd50 || rem2 == 7'd75);
    be3   <= be_c;
    sh3   <= sh_c;

    calc4 <= calc3;
    sign4 <= sign3;
    byp4  <= byp3;
    mant4 <= shifted_c[52:0];
    g4    <= q3[sh3 - 6'd1];
    s4    <= rs3 | ((q3 & lowmask_c) != '0);
    eff4  <= (be3 > 14'sd0) ? 11'(be3 - 14'sd1) : 11'd0;

    double_bits <= calc4 ? {sign4, mag_c} : byp4;
  end

endmodule

`default_nettype wire

@@ sv/rk_number_to_double_core.sv @@
// An accepted word passes the front stages, the queue and the back stages;
// done rises together with its result on double_bits.
// Throughput: one item per clock unless busy; a fixed divide pipeline.
// busy rises only when the front queue nears full, which cannot happen here
// since the receiver cannot stall and the back drains one entry per clock.
// Reset clears all valid flags and the queue pointers, not data registers.
`default_nettype none

module rk_number_to_double_core #(
  parameter int QUEUE_DEPTH = rkd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] rk_word,
  output logic             done,
  output logic [63:0]      double_bits
);
  import rkd_pkg::*;

  // Data registers and queue slots keep their contents through reset.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             fr_valid;
  rkd_item_t        fr_item;
  logic             hd_valid;
  rkd_item_t        hd_item;
  logic [CNT_W-1:0] level;

  // Hold off a transfer when items already in the front could overflow.
  assign busy   = (level > CNT_W'(QUEUE_DEPTH - IN_FLIGHT));
  assign accept = start && !busy;

  rkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .rk_word   (rk_word),
    .out_valid (fr_valid),
    .out_item  (fr_item)
  );

  rkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_item  (fr_item),
    .head_valid (hd_valid),
    .head_item  (hd_item),
    .level      (level)
  );

  rkd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (hd_valid),
    .in_item     (hd_item),
    .done        (done),
    .double_bits (double_bits)
  );

endmodule

`default_nettype wire
